// ===== src/tsl_pkg.sv =====
// Shared constants and controller/datapath interface types for the tournament selector.
package tsl_pkg;

  // 31-bit linear congruential generator
  localparam int unsigned RAND_W   = 31;
  localparam logic [30:0] LCG_MUL  = 31'd1103515245;
  localparam logic [30:0] LCG_ADD  = 31'd12345;
  localparam logic [30:0] RNG_SEED = 31'd54321;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_POP_SIZE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOUR_SIZE = 8'd1;

  // input kinds carried on tuser
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SELECT = 1'b1;

  // stream payload widths
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned FIT_IO_W  = 32;
  localparam int unsigned TDATA_W   = 40;

  // controller to datapath commands
  typedef struct packed {
    logic wr;        // store the accepted fitness beat
    logic start;     // begin a selection: load draw count
    logic lcg;       // advance generator, load modulo unit
    logic mod_step;  // one restoring-remainder step
    logic rd;        // read fitness store at the drawn index
    logic cmp;       // compare candidate against running best
    logic out_load;  // move winner into the output register
  } tsl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic mod_last;  // this modulo step is the last one
    logic draw_last; // the candidate in compare is the final draw
    logic out_free;  // output register can take a result now
  } tsl_stat_t;

endpackage

// ===== src/tournament_selector_lcg_core.sv =====
// Tournament selector: one item is in work at a time; the next beat is taken only after a
// select beat's result has moved into the output register, which may wait on out_tready.
// Each of the T draws (T = tournament size, min 1) runs one LCG step, a restoring remainder
// of the 31 generator bits by population size at one bit per cycle, one store read and one
// compare. A write beat is stored without leaving idle. Reset (rst_n, synchronous) sets the
// generator to 54321, population size 256, tournament size 2 and empties the output register.
module tournament_selector_lcg_core
  import tsl_pkg::*;
#(
  parameter int unsigned POP_MAX       = 256,
  parameter int unsigned FITNESS_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // slot[7:0], fitness_value[39:8]
  input  logic                  in_tuser,   // mode[0]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // winner_index[7:0], winner_fitness[39:8]
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  tsl_cmd_t  cmd;
  tsl_stat_t stat;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  tsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tsl_dpath #(
    .POP_MAX       (POP_MAX),
    .FITNESS_WIDTH (FITNESS_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ===== src/tsl_ctrl.sv =====
// Sequencer for fitness writes and tournament draws.
module tsl_ctrl
  import tsl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_tuser,
  output logic      in_tready,
  input  tsl_stat_t stat,
  output tsl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LCG,
    S_MOD,
    S_READ,
    S_CMP,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.wr       = (state_r == S_IDLE) && in_tvalid && (in_tuser == MODE_WRITE);
    cmd.start    = (state_r == S_IDLE) && in_tvalid && (in_tuser == MODE_SELECT);
    cmd.lcg      = (state_r == S_LCG);
    cmd.mod_step = (state_r == S_MOD);
    cmd.rd       = (state_r == S_READ);
    cmd.cmp      = (state_r == S_CMP);
    cmd.out_load = (state_r == S_OUT) && stat.out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd.start) state_nxt = S_LCG;
      S_LCG:  state_nxt = S_MOD;
      S_MOD:  if (stat.mod_last) state_nxt = S_READ;
      S_READ: state_nxt = S_CMP;
      S_CMP:  state_nxt = stat.draw_last ? S_OUT : S_LCG;
      S_OUT:  if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/tsl_dpath.sv =====
// Datapath: config registers, LCG, serial modulo, fitness store, compare and output register.
module tsl_dpath
  import tsl_pkg::*;
#(
  parameter int unsigned POP_MAX       = 256,
  parameter int unsigned FITNESS_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input payload
  input  logic [TDATA_W-1:0]    in_tdata,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,
  // control
  input  tsl_cmd_t              cmd,
  output tsl_stat_t             stat
);

  localparam int unsigned IW = (POP_MAX > 1) ? $clog2(POP_MAX) : 1;
  localparam int unsigned FW = FITNESS_WIDTH;
  localparam int unsigned BCW = $clog2(RAND_W);

  // configuration registers
  logic [8:0] pop_size_r;
  logic [4:0] tour_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_size_r  <= 9'd256;
      tour_size_r <= 5'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POP_SIZE:  pop_size_r  <= cfg_data;
        CFG_TOUR_SIZE: tour_size_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // effective population and draw count
  logic [8:0] n_eff;
  logic [4:0] draws_eff;

  always_comb begin
    if (pop_size_r == 9'd0) begin
      n_eff = 9'd1;
    end else if (32'(pop_size_r) > POP_MAX) begin
      n_eff = 9'(POP_MAX);
    end else begin
      n_eff = pop_size_r;
    end
    draws_eff = (tour_size_r == 5'd0) ? 5'd1 : tour_size_r;
  end

  // random generator, product kept mod 2^31
  logic [RAND_W-1:0] rng_r;
  logic [RAND_W-1:0] rng_prod;
  logic [RAND_W-1:0] rng_nxt;

  assign rng_prod = rng_r * LCG_MUL;
  assign rng_nxt  = rng_prod + LCG_ADD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r <= RNG_SEED;
    end else if (cmd.lcg) begin
      rng_r <= rng_nxt;
    end
  end

  // restoring remainder, one dividend bit per cycle
  logic [RAND_W-1:0] dvd_r;
  logic [8:0]        rem_r;
  logic [BCW-1:0]    bit_cnt_r;
  logic [9:0]        trial;
  logic              trial_ge;

  assign trial    = {rem_r, dvd_r[RAND_W-1]};
  assign trial_ge = (trial >= {1'b0, n_eff});

  always_ff @(posedge clk) begin
    if (cmd.lcg) begin
      dvd_r     <= rng_nxt;
      rem_r     <= '0;
      bit_cnt_r <= '0;
    end else if (cmd.mod_step) begin
      dvd_r     <= {dvd_r[RAND_W-2:0], 1'b0};
      rem_r     <= trial_ge ? 9'(trial - {1'b0, n_eff}) : trial[8:0];
      bit_cnt_r <= bit_cnt_r + 1'b1;
    end
  end

  assign stat.mod_last = (bit_cnt_r == BCW'(RAND_W - 1));

  // fitness store
  logic [FW-1:0]     mem [POP_MAX];
  logic [FW-1:0]     rd_data_r;
  logic [8:0]        cand_idx_r;
  logic [SLOT_W-1:0] wr_slot;
  logic [FW-1:0]     wr_val;

  assign wr_slot = in_tdata[SLOT_W-1:0];
  assign wr_val  = FW'($signed(in_tdata[SLOT_W +: FIT_IO_W]));

  always_ff @(posedge clk) begin
    if (cmd.wr && (32'(wr_slot) < POP_MAX)) begin
      mem[IW'(wr_slot)] <= wr_val;
    end
    if (cmd.rd) begin
      rd_data_r  <= mem[IW'(rem_r)];
      cand_idx_r <= rem_r;
    end
  end

  // running best over the draws
  logic [FW-1:0] best_fit_r;
  logic [8:0]    best_idx_r;
  logic          first_r;
  logic [4:0]    draw_cnt_r;
  logic          cand_less;

  assign cand_less      = ($signed(rd_data_r) < $signed(best_fit_r));
  assign stat.draw_last = (draw_cnt_r == 5'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r    <= 1'b0;
      draw_cnt_r <= '0;
    end else if (cmd.start) begin
      first_r    <= 1'b1;
      draw_cnt_r <= draws_eff - 5'd1;
    end else if (cmd.cmp) begin
      first_r    <= 1'b0;
      draw_cnt_r <= draw_cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp && (first_r || cand_less)) begin
      best_fit_r <= rd_data_r;
      best_idx_r <= cand_idx_r;
    end
  end

  // output register
  logic                out_valid_r;
  logic [TDATA_W-1:0]  out_data_r;

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {FIT_IO_W'(best_fit_r), best_idx_r[SLOT_W-1:0]};
    end
  end

endmodule
